// ===== hw/rtl/pxu_pkg.sv =====
// ----------------------------------------------------------------------------
// pxu_pkg
// shared types and constants of the pixel unpacker
// ----------------------------------------------------------------------------
package pxu_pkg;

   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int POS_W      = 12;
   localparam int FMT_W      = 4;
   localparam int DIM_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int BPP_W      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [FMT_W-1:0] {
      FMT_GREY       = 4'd0,
      FMT_GREY_ALPHA = 4'd1,
      FMT_RGB555     = 4'd2,
      FMT_RGB565     = 4'd3,
      FMT_RGB24      = 4'd4,
      FMT_BGR24      = 4'd5,
      FMT_RGB32      = 4'd6,
      FMT_ARGB       = 4'd7,
      FMT_RGBA       = 4'd8
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORMAT = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FMT_W-1:0] fmt;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   // one gathered pixel on its way from front to back
   typedef struct packed {
      logic [COLOR_W-1:0] bytes;
      logic [FMT_W-1:0]   fmt;
      logic [POS_W-1:0]   column;
      logic [POS_W-1:0]   row;
      logic               frame_end;
   } pix_rec_type;

   function automatic logic [BPP_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      logic [BPP_W-1:0] bpp;
      unique case (fmt)
         FMT_GREY:                             bpp = 3'd1;
         FMT_GREY_ALPHA, FMT_RGB555, FMT_RGB565: bpp = 3'd2;
         FMT_RGB24, FMT_BGR24:                 bpp = 3'd3;
         FMT_RGB32, FMT_ARGB, FMT_RGBA:        bpp = 3'd4;
         default:                              bpp = 3'd0;
      endcase
      return bpp;
   endfunction

endpackage

// ===== hw/rtl/pxu_front.sv =====
// ----------------------------------------------------------------------------
// pxu_front
// gathers source bytes into pixels and tracks the raster position
// ----------------------------------------------------------------------------
module pxu_front import pxu_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  cfg_type           cfg,
   output logic              rec_push,
   output pix_rec_type       rec
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
   localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_DIM);

   logic [1:0]         idx_ff, idx_in;
   logic [23:0]        held_ff, held_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;

   logic [BPP_W-1:0]   bpp;
   logic               known;
   logic               complete;
   logic [CMP_W-1:0]   w_lim, h_lim, w_raw, h_raw;
   logic               last_col, last_row;

   assign bpp      = bytes_per_pixel(cfg.fmt);
   assign known    = (bpp != '0);
   assign complete = known && ((BPP_W'(idx_ff) + 3'd1) >= bpp);

   // zero acts as one, oversize acts as the maximum
   assign w_raw = CMP_W'(cfg.width);
   assign h_raw = CMP_W'(cfg.height);
   assign w_lim = (w_raw == '0) ? CMP_W'(1) : ((w_raw > MAX_LIM) ? MAX_LIM : w_raw);
   assign h_lim = (h_raw == '0) ? CMP_W'(1) : ((h_raw > MAX_LIM) ? MAX_LIM : h_raw);

   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= w_lim;
   assign last_row = (CMP_W'(row_ff) + CMP_W'(1)) >= h_lim;

   always_comb begin
      idx_in  = idx_ff;
      held_in = held_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept && known) begin
         if (complete) begin
            idx_in = 2'd0;
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + CNT_W'(1);
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end else begin
            idx_in = idx_ff + 2'd1;
            unique case (idx_ff)
               2'd0:    held_in[7:0]   = data_byte;
               2'd1:    held_in[15:8]  = data_byte;
               2'd2:    held_in[23:16] = data_byte;
               default: held_in        = held_ff;
            endcase
         end
      end
   end

   // incoming byte replaces the held byte at the last position of the pixel
   always_comb begin
      rec.bytes[31:24] = (bpp == 3'd4) ? data_byte : '0;
      rec.bytes[23:16] = (bpp == 3'd3) ? data_byte : held_ff[23:16];
      rec.bytes[15:8]  = (bpp == 3'd2) ? data_byte : held_ff[15:8];
      rec.bytes[7:0]   = (bpp == 3'd1) ? data_byte : held_ff[7:0];
      rec.fmt          = cfg.fmt;
      rec.column       = POS_W'(col_ff);
      rec.row          = POS_W'(row_ff);
      rec.frame_end    = last_col && last_row;
   end

   assign rec_push = accept && complete;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         idx_ff  <= idx_in;
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

// ===== hw/rtl/pxu_queue.sv =====
// ----------------------------------------------------------------------------
// pxu_queue
// short pixel queue between the gathering front and the converting back
// ----------------------------------------------------------------------------
module pxu_queue import pxu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  pix_rec_type push_rec,
   input  logic        pop,
   output pix_rec_type pop_rec,
   output logic        not_empty,
   output logic        full
);

   pix_rec_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_rec   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/pxu_back.sv =====
// ----------------------------------------------------------------------------
// pxu_back
// converts queued pixels to argb and holds the result for the consumer
// ----------------------------------------------------------------------------
module pxu_back import pxu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pix_rec_type        rec,
   input  logic               rec_valid,
   output logic               rec_pop,
   input  logic               out_pop,
   output logic               out_valid,
   output logic [COLOR_W-1:0] argb_color,
   output logic [POS_W-1:0]   column,
   output logic [POS_W-1:0]   row,
   output logic               frame_end
);

   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [POS_W-1:0]   column_ff, row_ff;
   logic               frame_end_ff;
   logic               load;
   logic [7:0]         p0, p1, p2, p3;
   logic [15:0]        w16;

   assign p0  = rec.bytes[7:0];
   assign p1  = rec.bytes[15:8];
   assign p2  = rec.bytes[23:16];
   assign p3  = rec.bytes[31:24];
   assign w16 = {p1, p0};

   always_comb begin
      unique case (rec.fmt)
         FMT_GREY:       color_in = {ALPHA_OPAQUE, p0, p0, p0};
         FMT_GREY_ALPHA: color_in = {p1, p0, p0, p0};
         FMT_RGB555:     color_in = {ALPHA_OPAQUE, w16[14:10], 3'b000,
                                     w16[9:5], 3'b000, w16[4:0], 3'b000};
         FMT_RGB565:     color_in = {ALPHA_OPAQUE, w16[15:11], 3'b000,
                                     w16[10:5], 2'b00, w16[4:0], 3'b000};
         FMT_RGB24:      color_in = {ALPHA_OPAQUE, p0, p1, p2};
         FMT_BGR24:      color_in = {ALPHA_OPAQUE, p2, p1, p0};
         FMT_RGB32:      color_in = {ALPHA_OPAQUE, p2, p1, p0};
         FMT_ARGB:       color_in = {p3, p2, p1, p0};
         default:        color_in = {p3, p0, p1, p2};
      endcase
   end

   // refill the output register when it is empty or being taken
   assign load     = rec_valid && (!valid_ff || out_pop);
   assign rec_pop  = load;
   assign valid_in = load || (valid_ff && !out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff     <= color_in;
         column_ff    <= rec.column;
         row_ff       <= rec.row;
         frame_end_ff <= rec.frame_end;
      end
   end

   assign out_valid  = valid_ff;
   assign argb_color = color_ff;
   assign column     = column_ff;
   assign row        = row_ff;
   assign frame_end  = frame_end_ff;

endmodule

// ===== hw/rtl/pixel_unpack_to_argb32.sv =====
// ----------------------------------------------------------------------------
// pixel_unpack_to_argb32
// packed raster byte stream to 32-bit argb pixels with position
// ----------------------------------------------------------------------------
// One source byte is taken per request, and a byte can be pushed every clock
// cycle while req_full is low. Depending on the format one to four bytes make
// a pixel (grey, grey+alpha, rgb555, rgb565 little endian, rgb24, bgr24,
// rgb32, argb stored as b,g,r,a, rgba); the completed pixel comes out as argb
// (alpha in 31:24) with its column, row and a frame_end flag on the frame's
// last pixel, after which the position wraps to the origin. The front gathers
// bytes and counts position, a four-entry queue decouples it from the back,
// and the back converts and holds the result in an output register; after
// its last byte a pixel enters the queue and then that output register.
// req_full rises only when the queue is full, so a stalled consumer backs up
// the input after five pixels, four in the queue, one in the output register.
// Format codes above rgba make the block swallow bytes without a result.
// Dimension registers of zero act as one and values above MAX_DIM act as
// MAX_DIM. Registers are written through the csr channel, which is always
// ready; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_unpack_to_argb32 import pxu_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [BYTE_W-1:0]     req_data_byte,
   // pixel output
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COLOR_W-1:0]    rsp_argb_color,
   output logic [POS_W-1:0]      rsp_column,
   output logic [POS_W-1:0]      rsp_row,
   output logic                  rsp_frame_end,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   cfg_type     cfg_ff, cfg_in;

   logic        accept;
   logic        rec_push;
   pix_rec_type front_rec;
   pix_rec_type queue_rec;
   logic        queue_not_empty;
   logic        queue_full;
   logic        queue_pop;
   logic        out_valid;

   assign csr_ready = 1'b1;

   // register file, writes to unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FORMAT: cfg_in.fmt    = csr_data[FMT_W-1:0];
            CSR_WIDTH:  cfg_in.width  = csr_data[DIM_W-1:0];
            CSR_HEIGHT: cfg_in.height = csr_data[DIM_W-1:0];
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt    <= FMT_GREY;
         cfg_ff.width  <= DIM_W'(1);
         cfg_ff.height <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // full is the queue being full, independent of the byte's role
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // front: byte gathering and position counting
   pxu_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .rec_push  (rec_push),
      .rec       (front_rec)
   );

   // decoupling queue
   pxu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_rec  (front_rec),
      .pop       (queue_pop),
      .pop_rec   (queue_rec),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // back: conversion and output register
   pxu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rec        (queue_rec),
      .rec_valid  (queue_not_empty),
      .rec_pop    (queue_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .argb_color (rsp_argb_color),
      .column     (rsp_column),
      .row        (rsp_row),
      .frame_end  (rsp_frame_end)
   );

   assign rsp_empty = !out_valid;

endmodule
